### rtl/bavg_pkg.sv
// Shared types, constants and register map of the block averaging meter front end.
package bavg_pkg;

   // Word and count widths.
   localparam int DATA_W     = 32;
   localparam int COUNT_BITS = 10;
   localparam int NCH        = 11;
   localparam int SUM_W      = DATA_W + COUNT_BITS;
   localparam int CHAN_W     = $clog2(NCH);
   localparam int DIV_CNT_W  = $clog2(SUM_W);
   localparam int CSR_ADDR_W = 5;
   localparam int REG_SEL_W  = 3;

   // Channel indexes in input field order: the three range-checked channels and the last one.
   localparam logic [CHAN_W-1:0] CH_CURRENT_R   = CHAN_W'(0);
   localparam logic [CHAN_W-1:0] CH_VOLTAGE_R   = CHAN_W'(3);
   localparam logic [CHAN_W-1:0] CH_POWER_TOTAL = CHAN_W'(6);
   localparam logic [CHAN_W-1:0] CH_LAST        = CHAN_W'(NCH - 1);

   // Substitute values in Q16.16: 0.5, 220.0 and 0.2.
   localparam logic [DATA_W-1:0] SUB_CURRENT = 32'h0000_8000;
   localparam logic [DATA_W-1:0] SUB_VOLT    = 32'h00DC_0000;
   localparam logic [DATA_W-1:0] SUB_POWER   = 32'h0000_3333;

   // Register reset values.
   localparam logic [COUNT_BITS-1:0] RST_AVERAGE_COUNT = COUNT_BITS'(10);
   localparam logic [DATA_W-1:0]     RST_VOLT_MAX      = 32'd15728640;
   localparam logic [DATA_W-1:0]     RST_VOLT_MIN      = 32'd13107200;
   localparam logic [DATA_W-1:0]     RST_CURRENT_MAX   = 32'd655360;
   localparam logic [DATA_W-1:0]     RST_CURRENT_MIN   = 32'd0;
   localparam logic [DATA_W-1:0]     RST_POWER_MAX     = 32'd196608;
   localparam logic [DATA_W-1:0]     RST_POWER_MIN     = 32'd0;

   // Register indexes (byte address divided by four).
   typedef enum logic [REG_SEL_W-1:0] {
      REG_AVERAGE_COUNT = 3'd0,
      REG_VOLT_MAX      = 3'd1,
      REG_VOLT_MIN      = 3'd2,
      REG_CURRENT_MAX   = 3'd3,
      REG_CURRENT_MIN   = 3'd4,
      REG_POWER_MAX     = 3'd5,
      REG_POWER_MIN     = 3'd6
   } reg_sel_type;

   // One meter sample.
   typedef struct packed {
      logic signed [DATA_W-1:0] current_r;
      logic signed [DATA_W-1:0] current_s;
      logic signed [DATA_W-1:0] current_t;
      logic signed [DATA_W-1:0] voltage_r;
      logic signed [DATA_W-1:0] voltage_s;
      logic signed [DATA_W-1:0] voltage_t;
      logic signed [DATA_W-1:0] power_total;
      logic signed [DATA_W-1:0] power_net;
      logic signed [DATA_W-1:0] power_r;
      logic signed [DATA_W-1:0] power_s;
      logic signed [DATA_W-1:0] power_t;
   } req_type;

   // One set of averages.
   typedef struct packed {
      logic signed [DATA_W-1:0] avg_current_r;
      logic signed [DATA_W-1:0] avg_current_s;
      logic signed [DATA_W-1:0] avg_current_t;
      logic signed [DATA_W-1:0] avg_voltage_r;
      logic signed [DATA_W-1:0] avg_voltage_s;
      logic signed [DATA_W-1:0] avg_voltage_t;
      logic signed [DATA_W-1:0] avg_power_total;
      logic signed [DATA_W-1:0] avg_power_net;
      logic signed [DATA_W-1:0] avg_power_r;
      logic signed [DATA_W-1:0] avg_power_s;
      logic signed [DATA_W-1:0] avg_power_t;
   } rsp_type;

endpackage

### rtl/bavg_div.sv
// Restoring bit-serial divider of an unsigned sum magnitude by the sample count.
module bavg_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [bavg_pkg::SUM_W-1:0]      dividend,
   input  logic [bavg_pkg::COUNT_BITS-1:0] divisor,
   output logic                            done,
   output logic [bavg_pkg::SUM_W-1:0]      quotient
);
   import bavg_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] dsr_ff, dsr_in;
   logic [SUM_W-1:0]      quo_ff, quo_in;
   logic [COUNT_BITS:0]   trial;
   logic [COUNT_BITS:0]   diff;
   logic                  fits;

   // One quotient bit per cycle: the dividend shifts out of the top of the
   // quotient register while the new bits shift in at the bottom.
   always_comb begin
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      fits    = (trial >= {1'b0, dsr_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
         quo_in = {quo_ff[SUM_W-2:0], fits};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/block_average_with_range_substitute.sv
// Top level: averaging of eleven meter channels with range substitution.
// A summed sample is taken in the idle state, then one sum is updated a cycle.
// An emitting sample is taken in hand, then each channel in turn goes through the shared
// bit-serial divider (start, 42 steps, capture); its result is valid once the last average is captured.
// A result waits in an output register while summing carries on; the next emitting sample
// waits until it is taken. Synchronous reset restores defaults and clears sums and count.
module block_average_with_range_substitute (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bavg_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bavg_pkg::rsp_type                 rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bavg_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bavg_pkg::DATA_W-1:0]       csr_pwdata,
   output logic [bavg_pkg::DATA_W-1:0]       csr_prdata,
   output logic                              csr_pready
);
   import bavg_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SUM  = 4'b0010,
      ST_HOLD = 4'b0100,
      ST_DIV  = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [CHAN_W-1:0]        idx_ff, idx_in;
   logic                     wait_ff, wait_in;
   logic                     neg_ff, neg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;

   logic [COUNT_BITS-1:0]    avg_count_ff;
   logic signed [DATA_W-1:0] volt_max_ff, volt_min_ff;
   logic signed [DATA_W-1:0] current_max_ff, current_min_ff;
   logic signed [DATA_W-1:0] power_max_ff, power_min_ff;

   logic signed [SUM_W-1:0]  sum_ff [NCH];
   logic [DATA_W-1:0]        item_ff [NCH];
   logic [NCH-1:0][DATA_W-1:0] avg_ff;

   logic [NCH-1:0][DATA_W-1:0] in_words;
   logic [DATA_W-1:0]        checked [NCH];
   logic                     req_fire;
   logic                     csr_write;
   reg_sel_type              reg_sel;
   logic                     is_emit;
   logic signed [SUM_W-1:0]  sum_cur;
   logic [SUM_W-1:0]         sum_mag;
   logic                     div_start;
   logic                     div_done;
   logic [SUM_W-1:0]         div_quo;
   logic [SUM_W-1:0]         quo_neg;
   logic [DATA_W-1:0]        avg_word;
   logic [CHAN_W-1:0]        out_slot;

   assign req_fire  = req_valid & req_ready;
   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel   = reg_sel_type'(csr_paddr[REG_SEL_W+1:2]);
   assign in_words  = req_data;
   assign is_emit   = (count_ff >= avg_count_ff);
   assign sum_cur   = sum_ff[idx_ff];
   assign sum_mag   = sum_cur[SUM_W-1] ? SUM_W'(-sum_cur) : SUM_W'(sum_cur);
   assign div_start = (state_ff == ST_DIV) && !wait_ff;
   assign out_slot  = CH_LAST - idx_ff;

   // Range check of the three monitored channels; the rest pass unchanged.
   always_comb begin
      for (int i = 0; i < NCH; i++) begin
         checked[i] = in_words[NCH-1-i];
      end
      if ($signed(req_data.current_r) > current_max_ff ||
          $signed(req_data.current_r) < current_min_ff) begin
         checked[CH_CURRENT_R] = SUB_CURRENT;
      end
      if ($signed(req_data.voltage_r) > volt_max_ff ||
          $signed(req_data.voltage_r) < volt_min_ff) begin
         checked[CH_VOLTAGE_R] = SUB_VOLT;
      end
      if ($signed(req_data.power_total) > power_max_ff ||
          $signed(req_data.power_total) < power_min_ff) begin
         checked[CH_POWER_TOTAL] = SUB_POWER;
      end
   end

   // Restore the sign of a quotient and saturate it to a 32-bit word.
   always_comb begin
      quo_neg = -div_quo;
      if (neg_ff) begin
         if (div_quo[SUM_W-1:DATA_W] != '0 ||
             (div_quo[DATA_W-1] && div_quo[DATA_W-2:0] != '0)) begin
            avg_word = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            avg_word = quo_neg[DATA_W-1:0];
         end
      end else begin
         if (div_quo[SUM_W-1:DATA_W-1] != '0) begin
            avg_word = {1'b0, {(DATA_W-1){1'b1}}};
         end else begin
            avg_word = div_quo[DATA_W-1:0];
         end
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      wait_in      = wait_ff;
      neg_in       = neg_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && avg_count_ff != '0) begin
               idx_in = '0;
               if (is_emit) begin
                  count_in = '0;
                  state_in = ST_HOLD;
               end else begin
                  count_in = count_ff + COUNT_BITS'(1);
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            idx_in = idx_ff + CHAN_W'(1);
            if (idx_ff == CH_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff) begin
               wait_in  = 1'b0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!wait_ff) begin
               neg_in  = sum_cur[SUM_W-1];
               wait_in = 1'b1;
            end else if (div_done) begin
               wait_in = 1'b0;
               idx_in  = idx_ff + CHAN_W'(1);
               if (idx_ff == CH_LAST) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         wait_ff      <= 1'b0;
         neg_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         wait_ff      <= wait_in;
         neg_ff       <= neg_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Running sums: one channel added per cycle, cleared as it enters the divider.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCH; i++) begin
            sum_ff[i] <= '0;
         end
      end else if (state_ff == ST_SUM) begin
         sum_ff[idx_ff] <= sum_cur + SUM_W'($signed(item_ff[idx_ff]));
      end else if (div_start) begin
         sum_ff[idx_ff] <= '0;
      end
   end

   // Captured sample, already range checked.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < NCH; i++) begin
            item_ff[i] <= checked[i];
         end
      end
   end

   // Output register, one average written per division.
   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV && wait_ff && div_done) begin
         avg_ff[out_slot] <= avg_word;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         avg_count_ff   <= RST_AVERAGE_COUNT;
         volt_max_ff    <= RST_VOLT_MAX;
         volt_min_ff    <= RST_VOLT_MIN;
         current_max_ff <= RST_CURRENT_MAX;
         current_min_ff <= RST_CURRENT_MIN;
         power_max_ff   <= RST_POWER_MAX;
         power_min_ff   <= RST_POWER_MIN;
      end else if (csr_write) begin
         case (reg_sel)
            REG_AVERAGE_COUNT: avg_count_ff   <= csr_pwdata[COUNT_BITS-1:0];
            REG_VOLT_MAX:      volt_max_ff    <= csr_pwdata;
            REG_VOLT_MIN:      volt_min_ff    <= csr_pwdata;
            REG_CURRENT_MAX:   current_max_ff <= csr_pwdata;
            REG_CURRENT_MIN:   current_min_ff <= csr_pwdata;
            REG_POWER_MAX:     power_max_ff   <= csr_pwdata;
            REG_POWER_MIN:     power_min_ff   <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   // Register read-back; addresses past the map read as zero.
   always_comb begin
      case (reg_sel)
         REG_AVERAGE_COUNT: csr_prdata = DATA_W'(avg_count_ff);
         REG_VOLT_MAX:      csr_prdata = volt_max_ff;
         REG_VOLT_MIN:      csr_prdata = volt_min_ff;
         REG_CURRENT_MAX:   csr_prdata = current_max_ff;
         REG_CURRENT_MIN:   csr_prdata = current_min_ff;
         REG_POWER_MAX:     csr_prdata = power_max_ff;
         REG_POWER_MIN:     csr_prdata = power_min_ff;
         default:           csr_prdata = '0;
      endcase
   end

   // Shared divider.
   bavg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (avg_count_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = avg_ff;
   assign csr_pready = 1'b1;

endmodule
